// ===== hw/rtl/mi3_pkg.sv =====
// Shared types, constants and cofactor index tables for the 3x3 inverse.
// No dependencies.
`default_nettype none
package mi3_pkg;

	typedef logic signed [31:0] elem_t;

	// remainder / numerator width, enough for FRAC_BITS up to 31
	localparam int ACC_W     = 128;
	localparam int FRONT_STG = 5;
	localparam int DIV_STG   = 33;
	localparam int NUM_STG   = FRONT_STG + DIV_STG + 1;

	// adj[i] = a[A]*a[B] - a[C]*a[D], elements indexed row*3+col
	localparam int CF_A [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int CF_B [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int CF_C [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int CF_D [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	// per-item determinant info that travels beside the divider lanes
	typedef struct packed {
		logic               dzero;
		logic signed [31:0] dval;
		logic               dsat;
	} side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/matrix_inverse_3x3.sv =====
// Top level of the 3x3 fixed-point matrix inverse.
// Depends on mi3_pkg, mi3_front, mi3_div_lane, mi3_merge.
// One matrix enters per cycle while in_stall is low, and its result reaches the outputs
// through 39 register stages: five front stages (products, cofactors, split
// determinant products, determinant sum, magnitudes), nine divider lanes of 33 stages
// each (overflow check plus one quotient bit per stage), and the merge/output register.
// Every stage holds its item on a stall and fills bubbles ahead of it, so input keeps
// flowing while a result waits; in_stall rises only when every stage is full and
// out_stall is high.
`default_nettype none
module matrix_inverse_3x3 #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      b00, b01, b02, b10, b11, b12, b20, b21, b22,
	output logic signed [31:0]      det_value,
	output logic                    singular,
	output logic                    saturated
);

	localparam int NS = mi3_pkg::NUM_STG;
	localparam int FS = mi3_pkg::FRONT_STG;
	localparam int DS = mi3_pkg::DIV_STG;
	localparam int W  = mi3_pkg::ACC_W;

	logic [NS-1:0]   vld_q;
	logic [NS:0]     ld;
	mi3_pkg::elem_t  a [9];
	mi3_pkg::elem_t  b [9];
	logic [W-1:0]    num_mag [9];
	logic            num_neg [9];
	logic [W-1:0]    den;
	mi3_pkg::side_t  side_s5;
	mi3_pkg::side_t  side_q [DS];
	logic [32:0]     q_mag [9];
	logic            q_neg [9];

	assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	// a stage loads when empty or when its item moves on
	assign ld[NS] = !out_stall;
	for (genvar k = 0; k < NS; k++) begin : g_ld
		assign ld[k] = !vld_q[k] || ld[k+1];
	end
	assign in_stall = !ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (ld[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end
	assign out_valid = vld_q[NS-1];

	mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.ld      (ld[FS-1:0]),
		.a       (a),
		.num_mag (num_mag),
		.num_neg (num_neg),
		.den     (den),
		.side    (side_s5)
	);

	for (genvar i = 0; i < 9; i++) begin : g_lane
		mi3_div_lane u_lane (
			.clk     (clk),
			.ld      (ld[FS+DS-1:FS]),
			.num_mag (num_mag[i]),
			.num_neg (num_neg[i]),
			.den     (den),
			.q_mag   (q_mag[i]),
			.q_neg   (q_neg[i])
		);
	end

	// determinant info rides alongside the lanes
	always_ff @(posedge clk) begin
		if (ld[FS]) side_q[0] <= side_s5;
		for (int j = 1; j < DS; j++) begin
			if (ld[FS+j]) side_q[j] <= side_q[j-1];
		end
	end

	mi3_merge u_merge (
		.clk       (clk),
		.ld        (ld[NS-1]),
		.q_mag     (q_mag),
		.q_neg     (q_neg),
		.side      (side_q[DS-1]),
		.b         (b),
		.det_value (det_value),
		.singular  (singular),
		.saturated (saturated)
	);

	assign {b00, b01, b02, b10, b11, b12, b20, b21, b22} =
		{b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8]};

endmodule
`default_nettype wire

// ===== hw/rtl/mi3_front.sv =====
// Front end: products, cofactors, exact determinant, magnitudes for the lanes.
// Depends on mi3_pkg.
`default_nettype none
module mi3_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic [mi3_pkg::FRONT_STG-1:0] ld,
	input  wire mi3_pkg::elem_t              a [9],
	output logic [mi3_pkg::ACC_W-1:0]        num_mag [9],
	output logic                             num_neg [9],
	output logic [mi3_pkg::ACC_W-1:0]        den,
	output mi3_pkg::side_t                   side
);

	localparam int ACC_W = mi3_pkg::ACC_W;

	logic signed [63:0] prod_s1 [18];
	mi3_pkg::elem_t     a_s1 [3];
	mi3_pkg::elem_t     a_s2 [3];
	logic signed [64:0] adj_s2 [9];
	logic signed [64:0] adj_s3 [9];
	logic signed [64:0] lo_s3 [3];
	logic signed [64:0] hi_s3 [3];
	logic signed [64:0] adj_s4 [9];
	logic signed [98:0] det_s4;
	logic signed [98:0] det_sh;

	// s1: eighteen 32x32 products
	for (genvar i = 0; i < 9; i++) begin : g_prod
		always_ff @(posedge clk) begin
			if (ld[0]) begin
				prod_s1[2*i]   <= $signed(a[mi3_pkg::CF_A[i]]) * $signed(a[mi3_pkg::CF_B[i]]);
				prod_s1[2*i+1] <= $signed(a[mi3_pkg::CF_C[i]]) * $signed(a[mi3_pkg::CF_D[i]]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) a_s1 <= '{a[0], a[1], a[2]};
		if (ld[1]) a_s2 <= a_s1;
	end

	// s2: cofactors, exact at 65 bits
	for (genvar i = 0; i < 9; i++) begin : g_adj
		always_ff @(posedge clk) begin
			if (ld[1]) adj_s2[i] <= 65'(prod_s1[2*i]) - 65'(prod_s1[2*i+1]);
		end
	end

	// s3: first-row expansion, each 32x65 product split in two halves
	for (genvar j = 0; j < 3; j++) begin : g_part
		always_ff @(posedge clk) begin
			if (ld[2]) begin
				lo_s3[j] <= $signed(a_s2[j]) * $signed({1'b0, adj_s2[3*j][31:0]});
				hi_s3[j] <= $signed(a_s2[j]) * $signed(adj_s2[3*j][64:32]);
			end
		end
	end

	// s4: determinant sum
	always_ff @(posedge clk) begin
		if (ld[2]) adj_s3 <= adj_s2;
		if (ld[3]) begin
			adj_s4 <= adj_s3;
			det_s4 <= (99'(hi_s3[0]) <<< 32) + 99'(lo_s3[0])
				+ (99'(hi_s3[1]) <<< 32) + 99'(lo_s3[1])
				+ (99'(hi_s3[2]) <<< 32) + 99'(lo_s3[2]);
		end
	end

	assign det_sh = det_s4 >>> (2 * FRAC_BITS);

	// s5: magnitudes and determinant output value
	for (genvar i = 0; i < 9; i++) begin : g_num
		always_ff @(posedge clk) begin
			if (ld[4]) begin
				num_neg[i] <= adj_s4[i][64] ^ det_s4[98];
				num_mag[i] <= ACC_W'(adj_s4[i][64] ? 65'(-adj_s4[i]) : 65'(adj_s4[i]))
					<< (2 * FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			den        <= ACC_W'(det_s4[98] ? 99'(-det_s4) : 99'(det_s4));
			side.dzero <= (det_s4 == '0);
			if (det_sh[98:31] == '0 || det_sh[98:31] == '1) begin
				side.dval <= det_sh[31:0];
				side.dsat <= 1'b0;
			end else begin
				side.dval <= det_sh[98] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				side.dsat <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mi3_div_lane.sv =====
// One divider lane: restoring division, overflow check then one quotient bit per stage.
// Depends on mi3_pkg.
`default_nettype none
module mi3_div_lane (
	input  wire logic                          clk,
	input  wire logic [mi3_pkg::DIV_STG-1:0]   ld,
	input  wire logic [mi3_pkg::ACC_W-1:0]     num_mag,
	input  wire logic                          num_neg,
	input  wire logic [mi3_pkg::ACC_W-1:0]     den,
	output logic [32:0]                        q_mag,
	output logic                               q_neg
);

	localparam int W = mi3_pkg::ACC_W;
	localparam int S = mi3_pkg::DIV_STG;

	logic [W-1:0]  rem_s [S];
	logic [W-1:0]  den_s [S];
	logic [31:0]   quo_s [S];
	logic          ovf_s [S];
	logic          neg_s [S];

	// stage 0: quotient would need more than 32 bits
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rem_s[0] <= num_mag;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= (num_mag >> 32) >= den;
			neg_s[0] <= num_neg;
		end
	end

	// stages 1..32: bit 32-j of the quotient
	for (genvar j = 1; j < S; j++) begin : g_stg
		localparam int B = S - 1 - j;
		logic [W-1:0] top_part;
		logic [W-1:0] diff;
		logic         take;

		assign top_part = rem_s[j-1] >> B;
		assign take     = top_part >= den_s[j-1];
		assign diff     = ((top_part - den_s[j-1]) << B)
			| (rem_s[j-1] & ((W'(1) << B) - W'(1)));

		always_ff @(posedge clk) begin
			if (ld[j]) begin
				rem_s[j]    <= take ? diff : rem_s[j-1];
				den_s[j]    <= den_s[j-1];
				quo_s[j]    <= quo_s[j-1] | (take ? (32'(1) << B) : 32'(0));
				ovf_s[j]    <= ovf_s[j-1];
				neg_s[j]    <= neg_s[j-1];
			end
		end
	end

	assign q_mag = {ovf_s[S-1], quo_s[S-1]};
	assign q_neg = neg_s[S-1];

endmodule
`default_nettype wire

// ===== hw/rtl/mi3_merge.sv =====
// Merge stage: signs, saturation and flags of all lanes into the output register.
// Depends on mi3_pkg.
`default_nettype none
module mi3_merge (
	input  wire logic           clk,
	input  wire logic           ld,
	input  wire logic [32:0]    q_mag [9],
	input  wire logic           q_neg [9],
	input  wire mi3_pkg::side_t side,
	output mi3_pkg::elem_t      b [9],
	output logic signed [31:0]  det_value,
	output logic                singular,
	output logic                saturated
);

	mi3_pkg::elem_t val [9];
	logic [8:0]     sat;

	// clamp each lane's signed quotient
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			if (q_neg[i]) begin
				sat[i] = q_mag[i][32] || (q_mag[i][31] && q_mag[i][30:0] != '0);
				val[i] = sat[i] ? 32'sh8000_0000 : -$signed(q_mag[i][31:0]);
			end else begin
				sat[i] = q_mag[i][32] || q_mag[i][31];
				val[i] = sat[i] ? 32'sh7fff_ffff : $signed(q_mag[i][31:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			for (int i = 0; i < 9; i++) b[i] <= side.dzero ? '0 : val[i];
			det_value <= side.dzero ? '0 : side.dval;
			singular  <= side.dzero;
			saturated <= !side.dzero && ((|sat) || side.dsat);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mi3_chk.sv =====
// Port-level checks for matrix_inverse_3x3, bound to the top level.
// Depends on matrix_inverse_3x3 ports only.
`default_nettype none
module mi3_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
	input wire logic signed [31:0] det_value,
	input wire logic               singular,
	input wire logic               saturated
);

	// input backs up only when the whole pipe is full and blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output free");

	// singular result carries zero elements and no clamp
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && singular) |-> (b00 == 0 && b01 == 0 && b02 == 0
			&& b10 == 0 && b11 == 0 && b12 == 0 && b20 == 0 && b21 == 0 && b22 == 0
			&& det_value == 0 && !saturated))
		else $error("singular item with nonzero fields");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(b00) && $stable(det_value) && $stable(singular)))
		else $error("result changed under stall");

endmodule

bind matrix_inverse_3x3 mi3_chk u_chk (.*);
`default_nettype wire
